[rtl/bmml_pkg.sv]
// Shared widths, register codes and arithmetic helpers for the lazy Barrett multiplier.
package bmml_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_LOW  = 2'd2;

	localparam logic [WORD_W-1:0] MODULUS_RST    = 64'd2;
	localparam logic [WORD_W-1:0] RATIO_HIGH_RST = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] RATIO_LOW_RST  = 64'hFFFF_FFFF_FFFF_FFFF;

	// pipeline depth from input register to output register
	localparam int unsigned PIPE_DEPTH = 7;

	function automatic logic [WORD_W-1:0] mul32(input logic [HALF_W-1:0] x,
			input logic [HALF_W-1:0] y);
		logic [WORD_W-1:0] xe;
		logic [WORD_W-1:0] ye;
		xe = {{HALF_W{1'b0}}, x};
		ye = {{HALF_W{1'b0}}, y};
		return xe * ye;
	endfunction

	// full 128-bit product from its four 32x32 partials
	function automatic logic [2*WORD_W-1:0] join128(input logic [WORD_W-1:0] p00,
			input logic [WORD_W-1:0] p01, input logic [WORD_W-1:0] p10,
			input logic [WORD_W-1:0] p11);
		logic [2*WORD_W-1:0] acc;
		acc = {p11, p00} + {{HALF_W{1'b0}}, p01, {HALF_W{1'b0}}}
			+ {{HALF_W{1'b0}}, p10, {HALF_W{1'b0}}};
		return acc;
	endfunction

endpackage

[rtl/barrett_mod_multiply_lazy.sv]
// Top level: seven-stage pipelined lazy Barrett modular multiplier, 64-bit operands.
// One word enters per cycle while s_axis_tready is high, and the residues leave in the
// order the words came in. The depth comes from three rows of 32x32 multipliers
// (operand product, quotient estimate, modulus times quotient), each registered and
// followed by adding logic: one adding stage after the operand product, two for the
// quotient estimate and the final subtract in the output register. Every stage has
// its own valid bit and moves up when the stage after it is empty or moving, so bubbles
// close up and output back-pressure only stops the input once all seven stages are
// full. The residue is the low 64 bits of a*b - q*qe with no final correction. Write
// the three registers (modulus, then the two halves of floor((2^128-1)/modulus)) only
// while nothing is in flight; cfg_ready is always high.
module barrett_mod_multiply_lazy (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [2*bmml_pkg::WORD_W-1:0]    s_axis_tdata,  // multiplicand_a, multiplicand_b
	input  logic                             s_axis_tlast,  // in_last
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bmml_pkg::WORD_W-1:0]      m_axis_tdata,  // residue
	output logic                             m_axis_tlast,  // out_last
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bmml_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmml_pkg::WORD_W-1:0]      cfg_data
);

	localparam int unsigned W = bmml_pkg::WORD_W;
	localparam int unsigned H = bmml_pkg::HALF_W;

	logic [W-1:0] modulus_q, ratio_high_q, ratio_low_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;

	// stage 1: operand partials
	logic [W-1:0] ab00_s1, ab01_s1, ab10_s1, ab11_s1;
	// stage 2: 128-bit product
	logic [W-1:0] ph_s2, pl_s2;
	// stage 3: ratio partials
	logic [W-1:0] x00_s3, x01_s3, x10_s3, x11_s3;
	logic [W-1:0] y00_s3, y01_s3, y10_s3, y11_s3;
	logic [W-1:0] z00_s3;
	logic [H-1:0] z01_s3, z10_s3;
	logic [W-1:0] pl_s3;
	// stage 4: ph*cl, pl*ch, low half of ph*ch
	logic [2*W-1:0] x_s4, y_s4;
	logic [W-1:0]   z_s4, pl_s4;
	// stage 5: quotient estimate
	logic [W-1:0] qe_s5, pl_s5;
	// stage 6: modulus times quotient partials
	logic [W-1:0] m00_s6;
	logic [H-1:0] m01_s6, m10_s6;
	logic [W-1:0] pl_s6;
	// stage 7: output register
	logic [W-1:0] res_s7;

	logic [W-1:0]   a_in, b_in;
	logic [2*W-1:0] ab_full;
	logic [W:0]     lo_sum;
	logic [W-1:0]   hi_sum;
	logic [H-1:0]   mq_mid;

	// low 32 bits of a 32x32 product (only these reach the low 64 of the result)
	function automatic logic [H-1:0] mq_lo(input logic [H-1:0] x, input logic [H-1:0] y);
		logic [W-1:0] p;
		p = bmml_pkg::mul32(x, y);
		return p[H-1:0];
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= bmml_pkg::MODULUS_RST;
			ratio_high_q <= bmml_pkg::RATIO_HIGH_RST;
			ratio_low_q  <= bmml_pkg::RATIO_LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bmml_pkg::REG_MODULUS:    modulus_q    <= cfg_data;
				bmml_pkg::REG_RATIO_HIGH: ratio_high_q <= cfg_data;
				bmml_pkg::REG_RATIO_LOW:  ratio_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: a stage loads when it is empty or its contents move on
	assign adv7 = !v_s7 || m_axis_tready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = res_s7;
	assign m_axis_tlast  = last_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_axis_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
		end
	end

	assign a_in = s_axis_tdata[W-1:0];
	assign b_in = s_axis_tdata[2*W-1:W];

	assign ab_full = bmml_pkg::join128(ab00_s1, ab01_s1, ab10_s1, ab11_s1);

	// upper half of ph*cl + pl*ch: carry out of the low halves plus the high halves
	assign lo_sum = {1'b0, x_s4[W-1:0]} + {1'b0, y_s4[W-1:0]};
	assign hi_sum = x_s4[2*W-1:W] + y_s4[2*W-1:W] + {{(W-1){1'b0}}, lo_sum[W]};

	assign mq_mid = m01_s6 + m10_s6;

	// payload, no reset
	always_ff @(posedge clk) begin
		if (adv1) begin
			ab00_s1 <= bmml_pkg::mul32(a_in[H-1:0], b_in[H-1:0]);
			ab01_s1 <= bmml_pkg::mul32(a_in[H-1:0], b_in[W-1:H]);
			ab10_s1 <= bmml_pkg::mul32(a_in[W-1:H], b_in[H-1:0]);
			ab11_s1 <= bmml_pkg::mul32(a_in[W-1:H], b_in[W-1:H]);
			last_s1 <= s_axis_tlast;
		end
		if (adv2) begin
			ph_s2   <= ab_full[2*W-1:W];
			pl_s2   <= ab_full[W-1:0];
			last_s2 <= last_s1;
		end
		if (adv3) begin
			x00_s3  <= bmml_pkg::mul32(ph_s2[H-1:0], ratio_low_q[H-1:0]);
			x01_s3  <= bmml_pkg::mul32(ph_s2[H-1:0], ratio_low_q[W-1:H]);
			x10_s3  <= bmml_pkg::mul32(ph_s2[W-1:H], ratio_low_q[H-1:0]);
			x11_s3  <= bmml_pkg::mul32(ph_s2[W-1:H], ratio_low_q[W-1:H]);
			y00_s3  <= bmml_pkg::mul32(pl_s2[H-1:0], ratio_high_q[H-1:0]);
			y01_s3  <= bmml_pkg::mul32(pl_s2[H-1:0], ratio_high_q[W-1:H]);
			y10_s3  <= bmml_pkg::mul32(pl_s2[W-1:H], ratio_high_q[H-1:0]);
			y11_s3  <= bmml_pkg::mul32(pl_s2[W-1:H], ratio_high_q[W-1:H]);
			z00_s3  <= bmml_pkg::mul32(ph_s2[H-1:0], ratio_high_q[H-1:0]);
			z01_s3  <= mq_lo(ph_s2[H-1:0], ratio_high_q[W-1:H]);
			z10_s3  <= mq_lo(ph_s2[W-1:H], ratio_high_q[H-1:0]);
			pl_s3   <= pl_s2;
			last_s3 <= last_s2;
		end
		if (adv4) begin
			x_s4    <= bmml_pkg::join128(x00_s3, x01_s3, x10_s3, x11_s3);
			y_s4    <= bmml_pkg::join128(y00_s3, y01_s3, y10_s3, y11_s3);
			z_s4    <= z00_s3 + {z01_s3 + z10_s3, {H{1'b0}}};
			pl_s4   <= pl_s3;
			last_s4 <= last_s3;
		end
		if (adv5) begin
			qe_s5   <= hi_sum + z_s4;
			pl_s5   <= pl_s4;
			last_s5 <= last_s4;
		end
		if (adv6) begin
			m00_s6  <= bmml_pkg::mul32(modulus_q[H-1:0], qe_s5[H-1:0]);
			m01_s6  <= mq_lo(modulus_q[H-1:0], qe_s5[W-1:H]);
			m10_s6  <= mq_lo(modulus_q[W-1:H], qe_s5[H-1:0]);
			pl_s6   <= pl_s5;
			last_s6 <= last_s5;
		end
		if (adv7) begin
			res_s7  <= pl_s6 - (m00_s6 + {mq_mid, {H{1'b0}}});
			last_s7 <= last_s6;
		end
	end

endmodule

[rtl/bmml_checker.sv]
// Port-level checker for the lazy Barrett multiplier, bound to the top level.
module bmml_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [bmml_pkg::WORD_W-1:0]    m_axis_tdata,
	input logic                           m_axis_tlast
);

	logic [3:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else begin
			inflight_q <= inflight_q + {3'd0, in_acc} - {3'd0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled output word changed");

	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(bmml_pkg::PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 4'd0 |-> !m_axis_tvalid)
		else $error("output word with nothing accepted");

endmodule

bind barrett_mod_multiply_lazy bmml_checker u_bmml_checker (.*);

[tb/tb_barrett_mod_multiply_lazy.sv]
// Self-checking testbench for the lazy Barrett modular multiplier.
`timescale 1ns / 100ps

// Holds the register copy and the queue of residues still owed by the pipeline.
class residue_board;

	typedef struct packed {
		logic [bmml_pkg::WORD_W-1:0] residue;
		logic                        last;
	} residue_t;

	residue_t                    owed[$];
	logic [bmml_pkg::WORD_W-1:0] modulus;
	logic [bmml_pkg::WORD_W-1:0] ratio_hi;
	logic [bmml_pkg::WORD_W-1:0] ratio_lo;
	int                          errors;
	int                          checked;

	function new();
		modulus  = bmml_pkg::MODULUS_RST;
		ratio_hi = bmml_pkg::RATIO_HIGH_RST;
		ratio_lo = bmml_pkg::RATIO_LOW_RST;
		errors   = 0;
		checked  = 0;
	endfunction

	function void set_reg(input logic [bmml_pkg::CFG_IDX_W-1:0] idx,
			input logic [bmml_pkg::WORD_W-1:0] value);
		case (idx)
			bmml_pkg::REG_MODULUS:    modulus  = value;
			bmml_pkg::REG_RATIO_HIGH: ratio_hi = value;
			bmml_pkg::REG_RATIO_LOW:  ratio_lo = value;
			default: ;
		endcase
	endfunction

	function logic [bmml_pkg::WORD_W-1:0] lazy_residue(input logic [bmml_pkg::WORD_W-1:0] a,
			input logic [bmml_pkg::WORD_W-1:0] b);
		logic [2*bmml_pkg::WORD_W-1:0] prod;
		logic [2*bmml_pkg::WORD_W-1:0] inner;
		logic [bmml_pkg::WORD_W-1:0]   ph;
		logic [bmml_pkg::WORD_W-1:0]   pl;
		logic [bmml_pkg::WORD_W-1:0]   qe;
		prod  = {64'd0, a} * {64'd0, b};
		ph    = prod[127:64];
		pl    = prod[63:0];
		// cross terms summed mod 2^128, only the upper half feeds the estimate
		inner = {64'd0, ph} * {64'd0, ratio_lo} + {64'd0, pl} * {64'd0, ratio_hi};
		qe    = ph * ratio_hi + inner[127:64];
		return pl - modulus * qe;
	endfunction

	function void note_input(input logic [bmml_pkg::WORD_W-1:0] a,
			input logic [bmml_pkg::WORD_W-1:0] b, input logic last);
		residue_t item;
		item.residue = lazy_residue(a, b);
		item.last    = last;
		owed.push_back(item);
	endfunction

	function int pending();
		return owed.size();
	endfunction

	task report(input string msg);
		errors++;
		// keep the log readable if the design is badly broken
		if (errors <= 100)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task check_result(input logic [bmml_pkg::WORD_W-1:0] res, input logic last);
		residue_t item;
		if (owed.size() == 0) begin
			report($sformatf("residue %h arrived with nothing owed", res));
		end else begin
			item = owed.pop_front();
			checked++;
			if (res !== item.residue)
				report($sformatf("residue %h, predicted %h", res, item.residue));
			if (last !== item.last)
				report($sformatf("tlast %b, predicted %b", last, item.last));
		end
	endtask

endclass

module tb_barrett_mod_multiply_lazy;

	localparam logic [bmml_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [bmml_pkg::WORD_W-1:0]    ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [bmml_pkg::WORD_W-1:0]    TOP_BIT    = 64'h8000_0000_0000_0000;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} stall_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [2*bmml_pkg::WORD_W-1:0]     s_axis_tdata;  // multiplicand_a, multiplicand_b
	logic                              s_axis_tlast;  // in_last
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [bmml_pkg::WORD_W-1:0]       m_axis_tdata;  // residue
	logic                              m_axis_tlast;  // out_last
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [bmml_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [bmml_pkg::WORD_W-1:0]       cfg_data;

	residue_board board;
	int           words_sent = 0;
	int           settings_used = 1;
	stall_mode_t  stall_mode = STALL_NONE;
	int           mode_left = 0;
	int           run_left = 0;

	barrett_mod_multiply_lazy u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: back-pressure pattern switches at random between four modes
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(50, 300);
		end
		mode_left--;
		if (run_left == 0) begin
			case (stall_mode)
				STALL_NONE: begin
					m_axis_tready = 1'b1;
					run_left = 1;
				end
				STALL_COIN: begin
					m_axis_tready = 1'($urandom_range(0, 1));
					run_left = 1;
				end
				STALL_PERIODIC: begin
					m_axis_tready = !m_axis_tready;
					run_left = m_axis_tready ? 3 : 1;
				end
				default: begin
					m_axis_tready = !m_axis_tready;
					run_left = m_axis_tready ? $urandom_range(1, 6) : $urandom_range(1, 15);
				end
			endcase
		end
		run_left--;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tlast);
	end

	function automatic logic [127:0] ratio_of(input logic [bmml_pkg::WORD_W-1:0] q);
		return {128{1'b1}} / {64'd0, q};
	endfunction

	// operand mix: edge values and values near the modulus, otherwise full range
	function automatic logic [bmml_pkg::WORD_W-1:0] rand_operand(
			input logic [bmml_pkg::WORD_W-1:0] q);
		logic [bmml_pkg::WORD_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = 64'($urandom_range(0, 15));
			3: v = q - 64'($urandom_range(0, 3));
			4: v = 64'd1 << $urandom_range(0, 63);
			5: v = q + 64'($urandom_range(0, 3));
			6: v = ALL_ONES - 64'($urandom_range(0, 255));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// entered and left at a falling edge; tvalid stays high into the next word
	task automatic push_word(input logic [bmml_pkg::WORD_W-1:0] a,
			input logic [bmml_pkg::WORD_W-1:0] b, input logic last);
		s_axis_tdata  = {b, a};
		s_axis_tlast  = last;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(a, b, last);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic idle_input(input int cycles);
		s_axis_tvalid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bmml_pkg::CFG_IDX_W-1:0] idx,
			input logic [bmml_pkg::WORD_W-1:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic stream_random(input int count, input logic [bmml_pkg::WORD_W-1:0] q);
		int   burst_left;
		int   vec_left;
		logic last;
		burst_left = 0;
		vec_left   = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 2) != 0)
					idle_input($urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
			// mostly whole vectors, now and then a stray or missing tlast
			if (vec_left == 0)
				vec_left = $urandom_range(1, 32);
			last = (vec_left == 1);
			if ($urandom_range(0, 19) == 0)
				last = !last;
			vec_left--;
			push_word(rand_operand(q), rand_operand(q), last);
			burst_left--;
		end
		s_axis_tvalid = 1'b0;
	endtask

	task automatic config_phase(input logic [bmml_pkg::WORD_W-1:0] q,
			input logic [bmml_pkg::WORD_W-1:0] ch, input logic [bmml_pkg::WORD_W-1:0] cl);
		drain();
		write_reg(bmml_pkg::REG_MODULUS, q);
		write_reg(bmml_pkg::REG_RATIO_HIGH, ch);
		write_reg(bmml_pkg::REG_RATIO_LOW, cl);
		settings_used++;
		stream_random(175, q);
	endtask

	initial begin
		#2_000_000;
		$display("Timeout: pipeline did not deliver all residues");
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [bmml_pkg::WORD_W-1:0] rq;
		logic [127:0]                ratio;
		board         = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = bmml_pkg::REG_MODULUS;
		cfg_data      = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values, operand extremes
		push_word('0, '0, 1'b0);
		push_word('0, ALL_ONES, 1'b0);
		push_word(ALL_ONES, '0, 1'b1);
		push_word(ALL_ONES, ALL_ONES, 1'b0);
		push_word(ALL_ONES, 64'd1, 1'b1);
		push_word(64'd1, ALL_ONES, 1'b0);
		push_word(64'd1, 64'd1, 1'b0);
		idle_input(3);
		push_word(64'h1_0000_0000, 64'h1_0000_0000, 1'b0);
		push_word(TOP_BIT, TOP_BIT, 1'b1);
		push_word(TOP_BIT, 64'd2, 1'b0);
		push_word(ALL_ONES, 64'hFFFF_FFFF, 1'b0);
		push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
		push_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		push_word(64'd2, 64'd3, 1'b1);
		stream_random(160, bmml_pkg::MODULUS_RST);

		ratio = ratio_of(64'd3);
		config_phase(64'd3, ratio[127:64], ratio[63:0]);
		// largest modulus, ratio 2^64+1
		ratio = ratio_of(ALL_ONES);
		config_phase(ALL_ONES, ratio[127:64], ratio[63:0]);
		rq = {$urandom, $urandom} | TOP_BIT;
		ratio = ratio_of(rq);
		config_phase(rq, ratio[127:64], ratio[63:0]);
		rq = 64'($urandom_range(2, 1 << 20));
		ratio = ratio_of(rq);
		config_phase(rq, ratio[127:64], ratio[63:0]);
		ratio = ratio_of(64'd2);
		config_phase(64'd2, ratio[127:64], ratio[63:0]);
		// modulus below two, ratio not matching
		config_phase('0, ALL_ONES, ALL_ONES);
		drain();
		write_reg(REG_UNUSED, {$urandom, $urandom});
		config_phase(64'd1, {$urandom, $urandom}, {$urandom, $urandom});
		drain();
		write_reg(REG_UNUSED, ALL_ONES);
		stream_random(20, 64'd1);
		config_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		config_phase(ALL_ONES, '0, '0);

		drain();
		repeat (4 * bmml_pkg::PIPE_DEPTH) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d residues never arrived", board.pending()));
		$display("Sent %0d words under %0d register settings; %0d residues compared.",
			words_sent, settings_used, board.checked);
		$display("Input ran in bursts with gaps; output back-pressure varied throughout.");
		if (board.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
rtl/bmml_pkg.sv
rtl/barrett_mod_multiply_lazy.sv
rtl/bmml_checker.sv
tb/tb_barrett_mod_multiply_lazy.sv
